FILE: rtl/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, ignored while reset is high
`define MMG_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");

// next-cycle implication, ignored while reset is high
`define MMG_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("check failed");

// next-cycle implication that also holds across reset
`define MMG_ASSERT_RST(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error("check failed");

`endif

FILE: rtl/mmg_pkg.sv
// ---------------------------------------------------------------------------
// mmg_pkg
// shared constants, command and status types for the gap search block
// ---------------------------------------------------------------------------
`default_nettype none
package mmg_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int VAL_W      = 31;
  localparam int GAP_W      = 32;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIV_CNT_W  = $clog2(VAL_W + 1);

  localparam logic [GAP_W-1:0] GAP_NONE = {GAP_W{1'b1}};

  typedef struct packed {
    logic load_in;
    logic clr_set;
    logic set_ovf;
    logic pos_from_cnt;
    logic pos_dec;
    logic wr_shift;
    logic wr_place;
    logic cnt_inc;
    logic rd_pos;
    logic idx_clr;
    logic idx_inc;
    logic top_clr;
    logic top_upd;
    logic prev_ld;
    logic srch_init;
    logic mid_ld;
    logic need_clr;
    logic div_start;
    logic need_add;
    logic srch_upd;
    logic out_ld;
  } mmg_cmd_t;

  typedef struct packed {
    logic cnt_full;
    logic cnt_zero;
    logic pos_is_one;
    logic rd_gt;
    logic last;
    logic idx_zero;
    logic idx_last;
    logic gap_zero;
    logic div_done;
    logic low_le_high;
  } mmg_sts_t;

endpackage
`default_nettype wire

FILE: rtl/mmg_ram.sv
// ---------------------------------------------------------------------------
// mmg_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
`default_nettype none
module mmg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/mmg_div.sv
// ---------------------------------------------------------------------------
// mmg_div
// restoring divider, one quotient bit per cycle, done pulses with the result
// ---------------------------------------------------------------------------
`default_nettype none
module mmg_div import mmg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] dividend,
  input  wire logic [VAL_W-1:0] divisor,
  output logic                  done,
  output logic      [VAL_W-1:0] quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [VAL_W-1:0]     rem;
  logic [VAL_W-1:0]     dsr;
  logic [VAL_W:0]       shifted;
  logic [VAL_W:0]       trial;

  assign shifted = {rem, quot[VAL_W-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(VAL_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      if (!trial[VAL_W]) begin
        rem  <= trial[VAL_W-1:0];
        quot <= {quot[VAL_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[VAL_W-1:0];
        quot <= {quot[VAL_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mmg_datapath.sv
// ---------------------------------------------------------------------------
// mmg_datapath
// point store, insertion registers, gap scan and binary search arithmetic
// ---------------------------------------------------------------------------
`default_nettype none
module mmg_datapath import mmg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mmg_cmd_t         cmd,
  output mmg_sts_t              sts,
  input  wire logic [VAL_W-1:0] in_value,
  input  wire logic             in_last,
  input  wire logic             cfg_we,
  input  wire logic [VAL_W-1:0] cfg_wdata,
  output logic      [GAP_W-1:0] out_gap,
  output logic                  out_ovf
);

  logic [VAL_W-1:0]  budget;
  logic [VAL_W-1:0]  v_reg;
  logic              last_reg;
  logic [CNT_W-1:0]  cnt;
  logic              ovf;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] idx;
  logic [VAL_W-1:0]  prev;
  logic [VAL_W-1:0]  top;
  logic [GAP_W-1:0]  low;
  logic [GAP_W-1:0]  high;
  logic [VAL_W-1:0]  mid;
  logic [GAP_W-1:0]  need;
  logic [GAP_W-1:0]  best;

  logic [VAL_W-1:0]  rdata;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [VAL_W-1:0]  wdata;
  logic [VAL_W-1:0]  gap;
  logic [GAP_W-1:0]  span;
  logic [GAP_W-1:0]  mid_full;
  logic [GAP_W-1:0]  limit;
  logic [GAP_W:0]    sum;
  logic              fits;
  logic              div_done;
  logic [VAL_W-1:0]  quot;

  assign raddr    = cmd.rd_pos ? (pos - 1'b1) : idx;
  assign we       = cmd.wr_shift | cmd.wr_place;
  assign wdata    = cmd.wr_shift ? rdata : v_reg;
  assign gap      = rdata - prev;
  assign span     = high - low;
  assign mid_full = low + {1'b0, span[GAP_W-1:1]};
  assign limit    = {1'b0, budget} + GAP_W'(1);
  assign sum      = {1'b0, need} + {2'b0, quot};
  assign fits     = need <= {1'b0, budget};

  mmg_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (pos),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // pieces needed for one gap d > 0 are (d - 1) / mid
  mmg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (gap - 1'b1),
    .divisor  (mid),
    .done     (div_done),
    .quot     (quot)
  );

  always_comb begin
    sts.cnt_full    = cnt == CNT_W'(MAX_POINTS);
    sts.cnt_zero    = cnt == '0;
    sts.pos_is_one  = pos == ADDR_W'(1);
    sts.rd_gt       = rdata > v_reg;
    sts.last        = last_reg;
    sts.idx_zero    = idx == '0;
    sts.idx_last    = (CNT_W'(idx) + CNT_W'(1)) == cnt;
    sts.gap_zero    = gap == '0;
    sts.div_done    = div_done;
    sts.low_le_high = low <= high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
      cnt    <= '0;
      ovf    <= 1'b0;
    end else begin
      if (cfg_we) begin
        budget <= cfg_wdata;
      end
      if (cmd.clr_set) begin
        cnt <= '0;
        ovf <= 1'b0;
      end else begin
        if (cmd.cnt_inc) begin
          cnt <= cnt + 1'b1;
        end
        if (cmd.set_ovf) begin
          ovf <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v_reg    <= in_value;
      last_reg <= in_last;
    end
    if (cmd.pos_from_cnt) begin
      pos <= ADDR_W'(cnt);
    end else if (cmd.pos_dec) begin
      pos <= pos - 1'b1;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.prev_ld) begin
      prev <= rdata;
    end
    if (cmd.top_clr) begin
      top <= '0;
    end else if (cmd.top_upd && gap > top) begin
      top <= gap;
    end
    if (cmd.srch_init) begin
      low  <= GAP_W'(1);
      high <= {1'b0, top};
      best <= GAP_NONE;
    end else if (cmd.srch_upd) begin
      if (fits) begin
        best <= {1'b0, mid};
        high <= {1'b0, mid} - 1'b1;
      end else begin
        low <= {1'b0, mid} + 1'b1;
      end
    end
    if (cmd.mid_ld) begin
      mid <= mid_full[VAL_W-1:0];
    end
    // running sum saturates at budget + 1
    if (cmd.need_clr) begin
      need <= '0;
    end else if (cmd.need_add) begin
      need <= (sum >= {1'b0, limit}) ? limit : sum[GAP_W-1:0];
    end
    if (cmd.out_ld) begin
      out_gap <= best;
      out_ovf <= ovf;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mmg_ctrl.sv
// ---------------------------------------------------------------------------
// mmg_ctrl
// sequencer for sorted insertion, largest-gap scan and binary search probes
// ---------------------------------------------------------------------------
`default_nettype none
module mmg_ctrl import mmg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mmg_sts_t sts,
  output mmg_cmd_t      cmd,
  input  wire logic     s_valid,
  input  wire logic     s_last,
  output logic          s_ready,
  output logic          m_valid,
  input  wire logic     m_ready
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_CMP, S_PLACE, S_GREAD, S_GUSE, S_SINIT,
    S_SCHK, S_PREAD, S_PUSE, S_PDIV, S_PEVAL, S_DONE
  } state_t;

  state_t state, state_next;

  assign s_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.load_in = 1'b1;
          if (sts.cnt_full) begin
            cmd.set_ovf = 1'b1;
            if (s_last) begin
              cmd.idx_clr = 1'b1;
              cmd.top_clr = 1'b1;
              state_next  = S_GREAD;
            end
          end else begin
            cmd.pos_from_cnt = 1'b1;
            state_next       = sts.cnt_zero ? S_PLACE : S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.rd_pos = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.rd_gt) begin
          cmd.wr_shift = 1'b1;
          cmd.pos_dec  = 1'b1;
          state_next   = sts.pos_is_one ? S_PLACE : S_FETCH;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.wr_place = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.last) begin
          cmd.idx_clr = 1'b1;
          cmd.top_clr = 1'b1;
          state_next  = S_GREAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_GREAD: state_next = S_GUSE;
      S_GUSE: begin
        cmd.prev_ld = 1'b1;
        cmd.top_upd = !sts.idx_zero;
        if (sts.idx_last) begin
          state_next = S_SINIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_GREAD;
        end
      end
      S_SINIT: begin
        cmd.srch_init = 1'b1;
        state_next    = S_SCHK;
      end
      S_SCHK: begin
        if (sts.low_le_high) begin
          cmd.mid_ld   = 1'b1;
          cmd.need_clr = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_next   = S_PREAD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PREAD: state_next = S_PUSE;
      S_PUSE: begin
        cmd.prev_ld = 1'b1;
        if (sts.idx_zero) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_PREAD;
        end else if (sts.gap_zero) begin
          if (sts.idx_last) begin
            state_next = S_PEVAL;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_PREAD;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_PDIV;
        end
      end
      S_PDIV: begin
        if (sts.div_done) begin
          cmd.need_add = 1'b1;
          if (sts.idx_last) begin
            state_next = S_PEVAL;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_PREAD;
          end
        end
      end
      S_PEVAL: begin
        cmd.srch_upd = 1'b1;
        state_next   = S_SCHK;
      end
      S_DONE: begin
        if (!m_valid || m_ready) begin
          cmd.out_ld  = 1'b1;
          cmd.clr_set = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_ld) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/min_max_gap_after_insertion.sv
// a point goes into an empty store without a compare, else it is compared with
// c entries (those it moves past, plus one unless it reaches the front)
// a last point then starts the largest-gap scan over the n entries and about
// log2(largest gap) search probes; each probe runs the divider for every gap > 0
// throughput: one point at a time; a result may wait in the output register meanwhile
// reset: synchronous, clears count, overflow flag, budget and handshakes; store is not cleared
// ---------------------------------------------------------------------------
// min_max_gap_after_insertion
// sorted point loading and binary search for the smallest achievable gap
// ---------------------------------------------------------------------------
`default_nettype none
module min_max_gap_after_insertion import mmg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [31:0]      s_axis_tdata,  // [30:0] point_value
  input  wire logic             s_axis_tlast,  // point_last
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [31:0]      m_axis_tdata,  // [31:0] min_max_gap
  output logic                  m_axis_tuser,  // [0] capacity_overflow
  input  wire logic             cfg_we,
  input  wire logic [VAL_W-1:0] cfg_wdata
);

  mmg_cmd_t cmd;
  mmg_sts_t sts;

  mmg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .sts     (sts),
    .cmd     (cmd),
    .s_valid (s_axis_tvalid),
    .s_last  (s_axis_tlast),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready)
  );

  mmg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_value  (s_axis_tdata[VAL_W-1:0]),
    .in_last   (s_axis_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_gap   (m_axis_tdata),
    .out_ovf   (m_axis_tuser)
  );

endmodule
`default_nettype wire

FILE: rtl/mmg_checker.sv
// ---------------------------------------------------------------------------
// mmg_checker
// port-level checks for the gap search block
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mmg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // result leaves the block empty after reset
  `MMG_ASSERT_RST(a_rst_idle, rst, !m_axis_tvalid)

  // a stalled result beat holds
  `MMG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // gap is either none or non-negative
  `MMG_ASSERT_IMPL(a_gap_range, m_axis_tvalid,
    !m_axis_tdata[31] || m_axis_tdata == 32'hFFFF_FFFF)

  // a closing beat starts the search, so input stalls
  `MMG_ASSERT_NEXT(a_last_stall, s_axis_tvalid && s_axis_tready && s_axis_tlast,
    !s_axis_tready)

endmodule

bind min_max_gap_after_insertion mmg_checker u_mmg_checker (.*);
`default_nettype wire
